// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file ghp_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/ghp_pkg.sv =====
// shared types, constants and helpers for the handle pool
// no dependencies; used by the top level, controller and datapath
`default_nettype none

package ghp_pkg;

   // pool geometry
   localparam int SLOTS = 64;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // field widths
   localparam int OP_W = 2;
   localparam int HANDLE_W = 32;
   localparam int SLOT_FIELD_W = 6;
   localparam int STATUS_W = 3;
   localparam int GEN_W = 16;
   localparam int IDX_W = 8;
   localparam int TYPE_W = 5;

   // identity word layout
   localparam int GEN_LSB = 0;
   localparam int IDX_LSB = 16;
   localparam int TYPE_LSB = 24;
   localparam int ACTIVE_BIT = 31;

   // limit for index range checks, one bit wider than the index
   localparam logic [IDX_W:0] SLOTS_LIM = (IDX_W + 1)'(SLOTS);

   localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(1);
   localparam logic [TYPE_W-1:0] POOL_TYPE_RESET = TYPE_W'(5);

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd1;
   localparam logic [OP_W-1:0] OP_DEACTIVATE = 2'd2;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_BIT = 2;
   localparam logic REG_POOL_TYPE = 1'b0;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [HANDLE_W-1:0] handle;
      logic [SLOT_FIELD_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
      logic [SLOT_FIELD_W-1:0] slot_out;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   // identity word of a slot
   function automatic logic [HANDLE_W-1:0] identity(
      input logic active,
      input logic [TYPE_W-1:0] ptype,
      input logic [IDX_W-1:0] idx,
      input logic [GEN_W-1:0] gen
   );
      logic [HANDLE_W-1:0] id;
      id = '0;
      id[GEN_LSB +: GEN_W] = gen;
      id[IDX_LSB +: IDX_W] = idx;
      id[TYPE_LSB +: TYPE_W] = ptype;
      id[ACTIVE_BIT] = active;
      return id;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/generation_tagged_handle_pool.sv =====
// Generation-tagged handle pool. Each start transaction has an accept and an
// execute step: at acceptance the block captures the op, finds the lowest free
// slot and reads the slot's generation from the single-port generation memory;
// in the execute state it executes the op, writes the memory and marks back, and
// loads the result register. busy is high for that one execute cycle, and no new
// transaction is taken while busy. The result shows for exactly one cycle under
// rsp_strobe, on the cycle after execute, and must be taken then: the receiver
// cannot stall it. No clearing pass follows reset; per-slot valid bits make
// untouched generations read as one. pool_type is written over the APB port.
// depends on ghp_pkg, ghp_ctrl, ghp_datapath
`default_nettype none

module generation_tagged_handle_pool (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  ghp_pkg::req_type                    req_data,
   // result channel
   output logic                                rsp_strobe,
   output ghp_pkg::rsp_type                    rsp_data,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ghp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ghp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ghp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   ghp_pkg::cmd_type cmd;
   logic [ghp_pkg::TYPE_W-1:0] pool_type_ff, pool_type_in;
   logic csr_wr;
   logic csr_hit;

   // register write and read back
   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[ghp_pkg::CSR_IDX_BIT] == ghp_pkg::REG_POOL_TYPE);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign pool_type_in = csr_wr ? csr_pwdata[ghp_pkg::TYPE_W-1:0] : pool_type_ff;
   assign csr_prdata = csr_hit ? ghp_pkg::CSR_DATA_W'(pool_type_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_type_ff <= ghp_pkg::POOL_TYPE_RESET;
      end else begin
         pool_type_ff <= pool_type_in;
      end
   end

   // sequencer
   ghp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // slot state and result
   ghp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .pool_type (pool_type_ff),
      .rsp       (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/ghp_ctrl.sv =====
// controller for the handle pool: two-state sequencer and result strobe
// depends on ghp_pkg
`default_nettype none

module ghp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output ghp_pkg::cmd_type cmd,
   output logic             rsp_strobe
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands to the datapath
   assign cmd.load = start && (state_ff == ST_IDLE);
   assign cmd.exec = (state_ff == ST_EXEC);
   assign strobe_in = cmd.exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ===== hdl/ghp_datapath.sv =====
// datapath for the handle pool: slot marks, generation memory, result register
// depends on ghp_pkg
`default_nettype none

module ghp_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ghp_pkg::cmd_type               cmd,
   input  ghp_pkg::req_type               req,
   input  logic [ghp_pkg::TYPE_W-1:0]     pool_type,
   output ghp_pkg::rsp_type               rsp
);

   logic [ghp_pkg::SLOTS-1:0] busy_ff, busy_in;
   logic [ghp_pkg::SLOTS-1:0] active_ff, active_in;
   logic [ghp_pkg::SLOTS-1:0] gen_vld_ff, gen_vld_in;

   logic [ghp_pkg::GEN_W-1:0] gen_mem [ghp_pkg::SLOTS];
   logic [ghp_pkg::GEN_W-1:0] gen_rd_ff;
   logic                      gen_rd_vld_ff;

   ghp_pkg::req_type          req_ff;
   logic [ghp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      free_ff, free_in;
   logic [ghp_pkg::SLOT_W-1:0] free_idx;
   logic [ghp_pkg::SLOT_W-1:0] rd_addr, addr;

   ghp_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      in_range;
   logic                      wr_en;
   logic [ghp_pkg::GEN_W-1:0] gen_cur, gen_new;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      free_in = 1'b0;
      for (int i = ghp_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = ghp_pkg::SLOT_W'(i);
            free_in = 1'b1;
         end
      end
   end

   // slot index that the incoming op targets
   always_comb begin
      case (req.op)
         ghp_pkg::OP_ALLOC: begin
            idx_in = ghp_pkg::IDX_W'(free_idx);
         end
         ghp_pkg::OP_CHECK: begin
            idx_in = req.handle[ghp_pkg::IDX_LSB +: ghp_pkg::IDX_W];
         end
         default: begin
            idx_in = ghp_pkg::IDX_W'(req.slot);
         end
      endcase
   end

   assign rd_addr = idx_in[ghp_pkg::SLOT_W-1:0];
   assign addr = idx_ff[ghp_pkg::SLOT_W-1:0];
   assign in_range = ({1'b0, idx_ff} < ghp_pkg::SLOTS_LIM);

   // capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         idx_ff <= idx_in;
         free_ff <= free_in;
      end
   end

   // generation memory: read on load, write back on execute
   always_ff @(posedge clock) begin
      if (wr_en) gen_mem[addr] <= gen_new;
      if (cmd.load) gen_rd_ff <= gen_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) gen_rd_vld_ff <= gen_vld_ff[rd_addr];
   end

   // an unwritten entry reads as its reset generation
   assign gen_cur = gen_rd_vld_ff ? gen_rd_ff : ghp_pkg::GEN_RESET;
   assign gen_new = gen_cur + ghp_pkg::GEN_W'(1);

   // execute the op
   always_comb begin
      busy_in = busy_ff;
      active_in = active_ff;
      gen_vld_in = gen_vld_ff;
      wr_en = 1'b0;
      rsp_in = '0;
      rsp_in.status = ghp_pkg::ST_OK;
      if (cmd.exec) begin
         case (req_ff.op)
            ghp_pkg::OP_ALLOC: begin
               if (!free_ff) begin
                  rsp_in.status = ghp_pkg::ST_FULL;
               end else begin
                  wr_en = 1'b1;
                  gen_vld_in[addr] = 1'b1;
                  busy_in[addr] = 1'b1;
                  active_in[addr] = 1'b0;
                  rsp_in.handle_out = ghp_pkg::identity(1'b0, pool_type, idx_ff, gen_new);
                  rsp_in.slot_out = idx_ff[ghp_pkg::SLOT_FIELD_W-1:0];
               end
            end
            ghp_pkg::OP_ACTIVATE: begin
               rsp_in.slot_out = req_ff.slot;
               if (!in_range) begin
                  rsp_in.status = ghp_pkg::ST_RANGE;
               end else begin
                  active_in[addr] = 1'b1;
                  rsp_in.handle_out = ghp_pkg::identity(1'b1, pool_type, idx_ff, gen_cur);
               end
            end
            ghp_pkg::OP_DEACTIVATE: begin
               rsp_in.slot_out = req_ff.slot;
               if (!in_range) begin
                  rsp_in.status = ghp_pkg::ST_RANGE;
               end else begin
                  busy_in[addr] = 1'b0;
                  active_in[addr] = 1'b0;
                  rsp_in.handle_out = ghp_pkg::identity(1'b0, pool_type, idx_ff, gen_cur);
               end
            end
            ghp_pkg::OP_CHECK: begin
               if (req_ff.handle == '0) begin
                  rsp_in.status = ghp_pkg::ST_NOT_FOUND;
               end else if (req_ff.handle == '1) begin
                  rsp_in.status = ghp_pkg::ST_INVALID;
               end else if (req_ff.handle[ghp_pkg::TYPE_LSB +: ghp_pkg::TYPE_W] != pool_type) begin
                  rsp_in.status = ghp_pkg::ST_NOT_FOUND;
               end else if (!in_range) begin
                  rsp_in.status = ghp_pkg::ST_RANGE;
               end else if (ghp_pkg::identity(active_ff[addr], pool_type, idx_ff, gen_cur)
                            == req_ff.handle) begin
                  rsp_in.handle_out = req_ff.handle;
                  rsp_in.slot_out = idx_ff[ghp_pkg::SLOT_FIELD_W-1:0];
               end else begin
                  rsp_in.status = ghp_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_in.status = ghp_pkg::ST_OK;
            end
         endcase
      end
   end

   // slot marks
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         active_ff <= '0;
         gen_vld_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         active_ff <= active_in;
         gen_vld_ff <= gen_vld_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/ghp_checker.sv =====
// port-level timing checks for the handle pool, bound to the top level
// depends on assert_macros.svh and generation_tagged_handle_pool
`default_nettype none
`include "assert_macros.svh"

module ghp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // accepted transaction occupies the block for the following cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // execute lasts one cycle and is followed by the result
   `ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_strobe && !busy)

   // no result without a preceding execute cycle
   `ASSERT_SAME(a_result_origin, clock, reset, rsp_strobe, $past(busy))

   // one result per transaction
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind generation_tagged_handle_pool ghp_checker u_ghp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
